@@ sv/key_value_table_core_macros.svh @@
// assertion macros for the key/value table core
`ifndef KEY_VALUE_TABLE_CORE_MACROS_SVH
`define KEY_VALUE_TABLE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clock, off during reset
`define KVT_ASSERT_IMPL(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error("key value table check failed");
// next-cycle implication, sampled on clock, off during reset
`define KVT_ASSERT_NEXT(label, lhs, rhs) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error("key value table check failed");
`else
`define KVT_ASSERT_IMPL(label, lhs, rhs)
`define KVT_ASSERT_NEXT(label, lhs, rhs)
`endif
`endif

@@ sv/kvt_pkg.sv @@
// shared constants and types for the key/value table core
package kvt_pkg;
   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int WORD_BITS  = 32;
   localparam int IDX_BITS   = $clog2(ENTRIES);

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_UPDATE = 2'd1;
   localparam logic [1:0] MODE_REMOVE = 2'd2;
   localparam logic [1:0] MODE_LOOKUP = 2'd3;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_ABSENT  = 2'd1;
   localparam logic [1:0] ST_PRESENT = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } kvt_cmd_type;

   typedef struct packed {
      logic last;
   } kvt_sts_type;
endpackage

@@ sv/kvt_ctrl.sv @@
// controller state machine: accept, scan, commit, hand off the response
module kvt_ctrl
   import kvt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output kvt_cmd_type cmd,
   input  kvt_sts_type sts
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_LAST   = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       fire;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // output register must be free before a new word is loaded
   assign fire = (state_ff == S_COMMIT) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      cmd.start  = (state_ff == S_IDLE) && req_valid;
      cmd.issue  = (state_ff == S_SCAN);
      cmd.commit = fire;
      state_in   = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (sts.last) state_in = S_LAST;
         end
         S_LAST: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (fire) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

@@ sv/kvt_datapath.sv @@
// datapath: key and value stores, valid bits, scan counter, match tracking
module kvt_datapath
   import kvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  kvt_cmd_type          cmd,
   output kvt_sts_type          sts,
   input  logic [1:0]           req_mode,
   input  logic [WORD_BITS-1:0] req_key,
   input  logic [WORD_BITS-1:0] req_value,
   output logic [1:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_read_value
);
   logic [KEY_BITS-1:0]   key_store_ff [ENTRIES];
   logic [VALUE_BITS-1:0] value_store_ff [ENTRIES];
   logic [ENTRIES-1:0]    slot_valid_ff, slot_valid_in;

   logic [1:0]            mode_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;
   logic [IDX_BITS-1:0]   rd_idx_ff;
   logic                  cmp_en_ff;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] val_rd_ff;
   logic                  vld_rd_ff;

   logic                  hit_ff, hit_in;
   logic [IDX_BITS-1:0]   hit_idx_ff, hit_idx_in;
   logic [VALUE_BITS-1:0] hit_val_ff, hit_val_in;
   logic                  free_ff, free_in;
   logic [IDX_BITS-1:0]   free_idx_ff, free_idx_in;

   logic [1:0]            status_ff, status_in;
   logic [VALUE_BITS-1:0] rd_val_ff, rd_val_in;

   logic                  key_we, val_we;
   logic [IDX_BITS-1:0]   val_wa;

   assign sts.last       = (cnt_ff == IDX_BITS'(ENTRIES - 1));
   assign rsp_status     = status_ff;
   assign rsp_read_value = WORD_BITS'(rd_val_ff);

   // counter and first-match / first-free tracking
   always_comb begin
      cnt_in      = cnt_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_val_in  = hit_val_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (cmd.start) begin
         cnt_in  = '0;
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else begin
         if (cmd.issue) cnt_in = cnt_ff + 1'b1;
         if (cmp_en_ff) begin
            if (vld_rd_ff && (key_rd_ff == key_ff) && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = rd_idx_ff;
               hit_val_in = val_rd_ff;
            end
            if (!vld_rd_ff && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = rd_idx_ff;
            end
         end
      end
   end

   // decision at commit
   always_comb begin
      status_in     = status_ff;
      rd_val_in     = rd_val_ff;
      slot_valid_in = slot_valid_ff;
      key_we        = 1'b0;
      val_we        = 1'b0;
      val_wa        = free_idx_ff;
      if (cmd.commit) begin
         status_in = ST_ABSENT;
         rd_val_in = '0;
         unique case (mode_ff)
            MODE_INSERT: begin
               if (hit_ff) begin
                  status_in = ST_PRESENT;
               end else if (!free_ff) begin
                  status_in = ST_FULL;
               end else begin
                  key_we                     = 1'b1;
                  val_we                     = 1'b1;
                  slot_valid_in[free_idx_ff] = 1'b1;
                  status_in                  = ST_DONE;
               end
            end
            MODE_UPDATE: begin
               if (hit_ff) begin
                  val_we    = 1'b1;
                  val_wa    = hit_idx_ff;
                  status_in = ST_DONE;
               end
            end
            MODE_REMOVE: begin
               if (hit_ff) begin
                  slot_valid_in[hit_idx_ff] = 1'b0;
                  status_in                 = ST_DONE;
               end
            end
            MODE_LOOKUP: begin
               if (hit_ff) begin
                  rd_val_in = hit_val_ff;
                  status_in = ST_DONE;
               end
            end
            default: begin
               status_in = ST_ABSENT;
            end
         endcase
      end
   end

   // stores: one registered read and one write per cycle
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         key_rd_ff <= key_store_ff[cnt_ff];
         val_rd_ff <= value_store_ff[cnt_ff];
      end
      if (key_we) key_store_ff[free_idx_ff] <= key_ff;
      if (val_we) value_store_ff[val_wa] <= value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         cmp_en_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         cmp_en_ff     <= cmd.issue;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff  <= req_mode;
         key_ff   <= req_key[KEY_BITS-1:0];
         value_ff <= req_value[VALUE_BITS-1:0];
      end
      rd_idx_ff   <= cnt_ff;
      vld_rd_ff   <= slot_valid_ff[cnt_ff];
      hit_idx_ff  <= hit_idx_in;
      hit_val_ff  <= hit_val_in;
      free_idx_ff <= free_idx_in;
      status_ff   <= status_in;
      rd_val_ff   <= rd_val_in;
   end
endmodule

@@ sv/key_value_table_core.sv @@
// key/value table core: linear-search table of ENTRIES slots
// the response word is registered at commit, after every slot has been scanned and compared
// one request at a time: the next is held off until the commit, set by the slot scan
//   through the single read port of the key and value stores
// the next request is taken while an earlier response word still waits
// reset (synchronous, active high) marks every slot free; stores need none
`include "key_value_table_core_macros.svh"
module key_value_table_core
   import kvt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   input  logic [WORD_BITS-1:0] req_key,
   input  logic [WORD_BITS-1:0] req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [WORD_BITS-1:0] rsp_read_value
);
   // commands from the controller, scan status back
   kvt_cmd_type cmd;
   kvt_sts_type sts;

   // sequencing: idle -> scan every slot -> finish last compare -> commit
   kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // stores, valid bits, match search and response register
   kvt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_mode       (req_mode),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   // an accepted word holds off the next one while the scan runs
   `KVT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
   // a new response word only appears right after a commit
   `KVT_ASSERT_IMPL(a_rsp_from_commit, $rose(rsp_valid), $past(cmd.commit))
   // only a successful lookup returns a nonzero value
   `KVT_ASSERT_IMPL(a_value_only_done, rsp_valid && (rsp_read_value != '0),
                    rsp_status == ST_DONE)
endmodule
